/* rtl/ccls_pkg.sv */
// shared types, constants and keyword tables of the control message classifier
package ccls_pkg;

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // keyword lengths
   localparam logic [4:0] LOOKUP_LEN = 5'd18;
   localparam logic [4:0] REXMIT_LEN = 5'd14;
   localparam logic [4:0] REPLY_LEN  = 5'd14;

   // port digit limits
   localparam logic [2:0] PORT_MIN_DIGITS = 3'd4;
   localparam logic [2:0] PORT_MAX_DIGITS = 3'd5;

   // character codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // recognizer phases
   typedef enum logic [4:0] {
      PH_START     = 5'd0,
      PH_KW_LOOKUP = 5'd1,
      PH_KW_REXMIT = 5'd2,
      PH_KW_REPLY  = 5'd3,
      PH_RX_ZERO   = 5'd4,
      PH_RX_NUM    = 5'd5,
      PH_RX_COMMA  = 5'd6,
      PH_RP_IP0    = 5'd7,
      PH_RP_IP     = 5'd8,
      PH_RP_PORT   = 5'd9,
      PH_RP_NAME0  = 5'd10,
      PH_RP_NAME   = 5'd11,
      PH_DEAD      = 5'd12,
      PH_RX_FIRST  = 5'd22
   } phase_type;

   // message kinds
   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_REXMIT = 2'd1,
      KIND_REPLY  = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   // verdict handed from the front to the queue
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } verdict_type;

   // queue status seen by the top level
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } queue_status_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // lookup keyword, 18 bytes
   function automatic logic [7:0] lookup_char(logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:    c = 8'h5A;
         5'd1:    c = 8'h45;
         5'd2:    c = 8'h52;
         5'd3:    c = 8'h4F;
         5'd4:    c = 8'h5F;
         5'd5:    c = 8'h53;
         5'd6:    c = 8'h45;
         5'd7:    c = 8'h56;
         5'd8:    c = 8'h45;
         5'd9:    c = 8'h4E;
         5'd10:   c = 8'h5F;
         5'd11:   c = 8'h43;
         5'd12:   c = 8'h4F;
         5'd13:   c = 8'h4D;
         5'd14:   c = 8'h45;
         5'd15:   c = 8'h5F;
         5'd16:   c = 8'h49;
         5'd17:   c = 8'h4E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // retransmit keyword with its trailing space, 14 bytes
   function automatic logic [7:0] rexmit_char(logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:    c = 8'h4C;
         5'd1:    c = 8'h4F;
         5'd2:    c = 8'h55;
         5'd3:    c = 8'h44;
         5'd4:    c = 8'h45;
         5'd5:    c = 8'h52;
         5'd6:    c = 8'h5F;
         5'd7:    c = 8'h50;
         5'd8:    c = 8'h4C;
         5'd9:    c = 8'h45;
         5'd10:   c = 8'h41;
         5'd11:   c = 8'h53;
         5'd12:   c = 8'h45;
         5'd13:   c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // reply keyword with its trailing space, 14 bytes
   function automatic logic [7:0] reply_char(logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:    c = 8'h42;
         5'd1:    c = 8'h4F;
         5'd2:    c = 8'h52;
         5'd3:    c = 8'h45;
         5'd4:    c = 8'h57;
         5'd5:    c = 8'h49;
         5'd6:    c = 8'h43;
         5'd7:    c = 8'h5A;
         5'd8:    c = 8'h5F;
         5'd9:    c = 8'h48;
         5'd10:   c = 8'h45;
         5'd11:   c = 8'h52;
         5'd12:   c = 8'h45;
         5'd13:   c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* rtl/ccls_recognizer.sv */
// front end: byte-wise grammar recognizer that issues a verdict on the last byte
module ccls_recognizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  is_last,
   output ccls_pkg::verdict_type verdict
);

   ccls_pkg::phase_type phase_ff, phase_in, adv_phase;
   logic [4:0]          kwpos_ff, kwpos_in, adv_pos;
   logic [2:0]          portcnt_ff, portcnt_in, adv_cnt;

   // advance the recognizer by one byte
   always_comb begin
      adv_phase = phase_ff;
      adv_pos   = kwpos_ff;
      adv_cnt   = portcnt_ff;
      unique case (phase_ff)
         ccls_pkg::PH_START: begin
            adv_pos = 5'd1;
            priority if (data_byte == ccls_pkg::lookup_char(5'd0)) begin
               adv_phase = ccls_pkg::PH_KW_LOOKUP;
            end else if (data_byte == ccls_pkg::rexmit_char(5'd0)) begin
               adv_phase = ccls_pkg::PH_KW_REXMIT;
            end else if (data_byte == ccls_pkg::reply_char(5'd0)) begin
               adv_phase = ccls_pkg::PH_KW_REPLY;
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_KW_LOOKUP: begin
            if (kwpos_ff < ccls_pkg::LOOKUP_LEN &&
                data_byte == ccls_pkg::lookup_char(kwpos_ff)) begin
               adv_pos = kwpos_ff + 5'd1;
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_KW_REXMIT: begin
            if (kwpos_ff < ccls_pkg::REXMIT_LEN &&
                data_byte == ccls_pkg::rexmit_char(kwpos_ff)) begin
               adv_pos = kwpos_ff + 5'd1;
               if (kwpos_ff + 5'd1 == ccls_pkg::REXMIT_LEN) begin
                  adv_phase = ccls_pkg::PH_RX_FIRST;
               end
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_KW_REPLY: begin
            if (kwpos_ff < ccls_pkg::REPLY_LEN &&
                data_byte == ccls_pkg::reply_char(kwpos_ff)) begin
               adv_pos = kwpos_ff + 5'd1;
               if (kwpos_ff + 5'd1 == ccls_pkg::REPLY_LEN) begin
                  adv_phase = ccls_pkg::PH_RP_IP0;
               end
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         // first number of the list may be a lone zero
         ccls_pkg::PH_RX_FIRST: begin
            priority if (data_byte == ccls_pkg::CH_ZERO) begin
               adv_phase = ccls_pkg::PH_RX_ZERO;
            end else if (ccls_pkg::is_digit(data_byte)) begin
               adv_phase = ccls_pkg::PH_RX_NUM;
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_RX_ZERO: begin
            adv_phase = (data_byte == ccls_pkg::CH_COMMA) ? ccls_pkg::PH_RX_COMMA
                                                          : ccls_pkg::PH_DEAD;
         end
         ccls_pkg::PH_RX_NUM: begin
            if (data_byte == ccls_pkg::CH_COMMA) begin
               adv_phase = ccls_pkg::PH_RX_COMMA;
            end else if (!ccls_pkg::is_digit(data_byte)) begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_RX_COMMA: begin
            adv_phase = (ccls_pkg::is_digit(data_byte) && data_byte != ccls_pkg::CH_ZERO)
                        ? ccls_pkg::PH_RX_NUM : ccls_pkg::PH_DEAD;
         end
         ccls_pkg::PH_RP_IP0: begin
            adv_phase = (ccls_pkg::is_digit(data_byte) || data_byte == ccls_pkg::CH_DOT)
                        ? ccls_pkg::PH_RP_IP : ccls_pkg::PH_DEAD;
         end
         ccls_pkg::PH_RP_IP: begin
            if (data_byte == ccls_pkg::CH_SPACE) begin
               adv_phase = ccls_pkg::PH_RP_PORT;
               adv_cnt   = 3'd0;
            end else if (!ccls_pkg::is_digit(data_byte) && data_byte != ccls_pkg::CH_DOT) begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         // port: no leading zero, four or five digits
         ccls_pkg::PH_RP_PORT: begin
            if (ccls_pkg::is_digit(data_byte)) begin
               if ((portcnt_ff == 3'd0 && data_byte == ccls_pkg::CH_ZERO) ||
                   portcnt_ff >= ccls_pkg::PORT_MAX_DIGITS) begin
                  adv_phase = ccls_pkg::PH_DEAD;
               end else begin
                  adv_cnt = portcnt_ff + 3'd1;
               end
            end else if (data_byte == ccls_pkg::CH_SPACE &&
                         portcnt_ff >= ccls_pkg::PORT_MIN_DIGITS) begin
               adv_phase = ccls_pkg::PH_RP_NAME0;
            end else begin
               adv_phase = ccls_pkg::PH_DEAD;
            end
         end
         ccls_pkg::PH_RP_NAME0, ccls_pkg::PH_RP_NAME: begin
            adv_phase = (data_byte >= ccls_pkg::CH_SPACE && data_byte <= ccls_pkg::CH_DEL)
                        ? ccls_pkg::PH_RP_NAME : ccls_pkg::PH_DEAD;
         end
         default: begin
            adv_phase = ccls_pkg::PH_DEAD;
         end
      endcase
   end

   // next state: advance on each transaction, restart after the last byte
   always_comb begin
      phase_in   = phase_ff;
      kwpos_in   = kwpos_ff;
      portcnt_in = portcnt_ff;
      if (take) begin
         if (is_last) begin
            phase_in   = ccls_pkg::PH_START;
            kwpos_in   = 5'd0;
            portcnt_in = 3'd0;
         end else begin
            phase_in   = adv_phase;
            kwpos_in   = adv_pos;
            portcnt_in = adv_cnt;
         end
      end
   end

   // verdict of the advanced state
   always_comb begin
      verdict.valid = take & is_last;
      priority if (adv_phase == ccls_pkg::PH_KW_LOOKUP && adv_pos == ccls_pkg::LOOKUP_LEN) begin
         verdict.kind = ccls_pkg::KIND_LOOKUP;
      end else if (adv_phase == ccls_pkg::PH_RX_ZERO || adv_phase == ccls_pkg::PH_RX_NUM) begin
         verdict.kind = ccls_pkg::KIND_REXMIT;
      end else if (adv_phase == ccls_pkg::PH_RP_NAME) begin
         verdict.kind = ccls_pkg::KIND_REPLY;
      end else begin
         verdict.kind = ccls_pkg::KIND_ERROR;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ccls_pkg::PH_START;
         kwpos_ff   <= 5'd0;
         portcnt_ff <= 3'd0;
      end else begin
         phase_ff   <= phase_in;
         kwpos_ff   <= kwpos_in;
         portcnt_ff <= portcnt_in;
      end
   end

endmodule

/* rtl/ccls_queue.sv */
// small verdict queue between the recognizer and the output stage
module ccls_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ccls_pkg::verdict_type      push_verdict,
   input  logic                       pop,
   output ccls_pkg::kind_type         head_kind,
   output ccls_pkg::queue_status_type status
);

   ccls_pkg::kind_type                entry_ff [ccls_pkg::QUEUE_DEPTH];
   logic [ccls_pkg::QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [ccls_pkg::QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [ccls_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   // status and head
   assign status.count = count_ff;
   assign status.full  = (count_ff == ccls_pkg::QCNT_W'(ccls_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_kind    = entry_ff[rptr_ff];

   assign do_push = push_verdict.valid & ~status.full;
   assign do_pop  = pop & ~status.empty;

   // pointer and count update
   always_comb begin
      wptr_in  = do_push ? wptr_ff + ccls_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + ccls_pkg::QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ccls_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ccls_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_verdict.kind;
      end
   end

endmodule

/* rtl/ccls_out_stage.sv */
// back end: output register that presents the oldest verdict on the result side
module ccls_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  ccls_pkg::kind_type queue_kind,
   output logic               queue_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_message_kind
);

   logic               valid_ff, valid_in;
   ccls_pkg::kind_type kind_ff, kind_in;

   // refill when the register is free or its transaction completes
   assign queue_pop = ~queue_empty & (~valid_ff | rsp_pop);

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      if (queue_pop) begin
         valid_in = 1'b1;
         kind_in  = queue_kind;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign rsp_empty        = ~valid_ff;
   assign rsp_message_kind = kind_ff;

endmodule

/* rtl/control_message_classifier.sv */
// top level of the control message classifier
//
// Request side: one message byte per transaction on req_data_byte, with
// req_is_last high on its final byte. A byte is taken at a clock edge with
// req_push high and req_full low. Bytes may follow each other in every cycle.
// Response side: one message kind per message (0 lookup, 1 rexmit, 2 reply,
// 3 error), shown while rsp_empty is low and taken at an edge with rsp_pop
// high. Non-final bytes give no response.
// The kind of a message is pushed into the queue at the edge that takes its
// last byte and moves into the output register once that is free or drained.
// Throughput is one byte per cycle while req_full stays low; the result side
// drains one kind per cycle while rsp_pop is held high.
// A four-entry queue plus the output register hold finished kinds; when the
// receiver stalls and the queue fills, req_full rises and input stalls too,
// with the partially parsed message kept in the recognizer.
// Reset clears the recognizer to the start of a message and empties the
// queue and the output register.
module control_message_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_message_kind
);

   logic                       take;
   ccls_pkg::verdict_type      verdict;
   ccls_pkg::kind_type         head_kind;
   ccls_pkg::queue_status_type qstat;
   logic                       queue_pop;

   // input transaction
   assign take     = req_push & ~req_full;
   assign req_full = qstat.full;

   ccls_recognizer u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .is_last   (req_is_last),
      .verdict   (verdict)
   );

   ccls_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_verdict (verdict),
      .pop          (queue_pop),
      .head_kind    (head_kind),
      .status       (qstat)
   );

   ccls_out_stage u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (qstat.empty),
      .queue_kind       (head_kind),
      .queue_pop        (queue_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_message_kind (rsp_message_kind)
   );

   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= ccls_pkg::QCNT_W'(ccls_pkg::QUEUE_DEPTH))
      else $error("verdict queue count above depth");

   // a final byte always leaves a kind somewhere downstream
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      take && req_is_last |=> !(qstat.empty && rsp_empty))
      else $error("final byte produced no pending kind");

   // a non-final byte never adds a queue entry
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      take && !req_is_last && !queue_pop |=> $stable(qstat.count))
      else $error("non-final byte changed queue occupancy");

   // a kind is moved into the output register only when it is free or drained
   a_refill_ok: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (rsp_empty || rsp_pop))
      else $error("output register overwritten while held");

endmodule
